[src/srp_pkg.sv]
// shared types and constants for the seeded register permutation block
// no dependencies; imported by every module of the block
`default_nettype none

package srp_pkg;

   // widths fixed by the result fields
   localparam int IDX_W  = 5;          // table index and entry value
   localparam int DIV_W  = IDX_W + 1;  // modulus (i+1), up to 32
   localparam int SEED_W = 64;
   localparam int BYTE_W = 8;

   // seed fold: seed * FOLD_MUL + byte + FOLD_ADD
   localparam logic [31:0]       FOLD_MUL = 32'd1315423911;
   localparam logic [SEED_W-1:0] FOLD_ADD = 64'h9E37_79B9_7F4A_7C15;

   // xorshift64 shift amounts
   localparam int XS_A = 13;
   localparam int XS_B = 7;
   localparam int XS_C = 17;

   // request to the permutation table memory
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_a_addr;
      logic [IDX_W-1:0] rd_b_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_data;
      logic             clear;
   } tbl_req_type;

   // registered read data of the table
   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
   } tbl_rd_type;

endpackage

`default_nettype wire

[src/srp_table.sv]
// permutation table: one write port, two registered read ports
// entries never written since the last clear read as their own index; uses srp_pkg
`default_nettype none

module srp_table
   import srp_pkg::*;
#(
   parameter int DEPTH = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire tbl_req_type req,
   output tbl_rd_type       rd
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [IDX_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   tbl_rd_type       rd_ff;

   // storage
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
      end
   end

   // valid bits, cleared at once to bring back the identity
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr[ADDR_W-1:0]] <= 1'b1;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_ff.a <= valid_ff[req.rd_a_addr[ADDR_W-1:0]] ?
                    mem[req.rd_a_addr[ADDR_W-1:0]] : req.rd_a_addr;
         rd_ff.b <= valid_ff[req.rd_b_addr[ADDR_W-1:0]] ?
                    mem[req.rd_b_addr[ADDR_W-1:0]] : req.rd_b_addr;
      end
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

[src/srp_fold.sv]
// seed fold unit: seed * FOLD_MUL + byte + FOLD_ADD mod 2^64
// four-stage pipeline with two 32x32 partial products; uses srp_pkg
`default_nettype none

module srp_fold
   import srp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SEED_W-1:0] seed,
   input  wire logic [BYTE_W-1:0] key_byte,
   output logic                   done,
   output logic [SEED_W-1:0]      result
);

   logic [3:0]        vld_ff;
   logic [31:0]       s_lo_ff;
   logic [31:0]       s_hi_ff;
   logic [SEED_W-1:0] bc_ff;
   logic [SEED_W-1:0] p_lo_ff;
   logic [31:0]       p_hi_ff;
   logic [SEED_W-1:0] bc1_ff;
   logic [SEED_W-1:0] t_ff;
   logic [31:0]       p_hi2_ff;
   logic [SEED_W-1:0] result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      // capture
      if (start) begin
         s_lo_ff <= seed[31:0];
         s_hi_ff <= seed[63:32];
         bc_ff   <= {{(SEED_W-BYTE_W){1'b0}}, key_byte} + FOLD_ADD;
      end
      // partial products
      p_lo_ff <= {32'd0, s_lo_ff} * {32'd0, FOLD_MUL};
      p_hi_ff <= s_hi_ff * FOLD_MUL;
      bc1_ff  <= bc_ff;
      // low product plus addend
      t_ff     <= p_lo_ff + bc1_ff;
      p_hi2_ff <= p_hi_ff;
      // upper half gets the high partial product
      result_ff <= {t_ff[63:32] + p_hi2_ff, t_ff[31:0]};
   end

   assign done   = vld_ff[3];
   assign result = result_ff;

endmodule

`default_nettype wire

[src/srp_modulo.sv]
// bit-serial remainder unit: 64-bit dividend mod a 6-bit divisor
// one dividend bit per cycle; uses srp_pkg
`default_nettype none

module srp_modulo
   import srp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SEED_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]  divisor,
   output logic                   done,
   output logic [IDX_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(SEED_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SEED_W-1:0] div_ff;
   logic [DIV_W-1:0]  dsr_ff;
   logic [IDX_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  trial;
   logic [IDX_W-1:0]  rem_in;

   // shift in next bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, div_ff[SEED_W-1]};
      if (trial >= dsr_ff) begin
         rem_in = IDX_W'(trial - dsr_ff);
      end else begin
         rem_in = trial[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(SEED_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         div_ff <= {div_ff[SEED_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[src/seeded_register_permutation.sv]
// seeded register permutation: key bytes fold into a seed, the last byte triggers a
// shuffle of a REG_COUNT-entry table, then the table is streamed out one beat per entry
// a key byte that is not the last returns to ready once its seed fold is done
// last byte: fold, then REG_COUNT-1 shuffle steps, each waiting on the bit-serial
// remainder unit, a fixed-point count with a possible 0/1 swap, then result beats
// held while rsp_tready is low; reset is synchronous, clears seed, counter and table
`default_nettype none

module seeded_register_permutation
   import srp_pkg::*;
#(
   parameter int REG_COUNT = 31,
   parameter int KEY_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // key byte channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] key_byte
   // table entry channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [4:0] slot, [9:5] target, [15:10] zero
   output logic             rsp_tlast    // last_entry
);

   localparam int CNT_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(REG_COUNT - 1);

   // sequencer states
   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,  // waiting for a key byte
      S_FOLD = 12'b0000_0000_0010,  // seed fold in flight
      S_XS   = 12'b0000_0000_0100,  // step the generator, start remainder
      S_MOD  = 12'b0000_0000_1000,  // remainder in flight
      S_RD   = 12'b0000_0001_0000,  // read entries k and j
      S_WK   = 12'b0000_0010_0000,  // write entry k
      S_WJ   = 12'b0000_0100_0000,  // write entry j
      S_CRD  = 12'b0000_1000_0000,  // fixed-point scan read
      S_CCHK = 12'b0001_0000_0000,  // fixed-point scan compare
      S_FIX  = 12'b0010_0000_0000,  // decide on the 0/1 swap
      S_ERD  = 12'b0100_0000_0000,  // emission read
      S_ELD  = 12'b1000_0000_0000   // emission load to output
   } state_type;

   state_type         state_ff, state_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [DIV_W-1:0]  fixed_ff, fixed_in;
   logic              fix_ff, fix_in;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_slot_ff;
   logic [IDX_W-1:0]  rsp_target_ff;
   logic              rsp_last_ff;
   logic              rsp_load;

   logic              req_accept;
   logic              fold_done;
   logic [SEED_W-1:0] fold_result;
   logic              mod_start;
   logic              mod_done;
   logic [IDX_W-1:0]  mod_rem;
   logic [SEED_W-1:0] xs_a, xs_b, xs_next;
   tbl_req_type       tbl_req;
   tbl_rd_type        tbl_rd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // xorshift64 step of the current seed
   always_comb begin
      xs_a    = seed_ff ^ (seed_ff << XS_A);
      xs_b    = xs_a ^ (xs_a >> XS_B);
      xs_next = xs_b ^ (xs_b << XS_C);
   end

   srp_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .seed     (seed_ff),
      .key_byte (req_tdata),
      .done     (fold_done),
      .result   (fold_result)
   );

   srp_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (xs_next),
      .divisor   ({1'b0, k_ff} + 1'b1),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   srp_table #(
      .DEPTH (REG_COUNT)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .req   (tbl_req),
      .rd    (tbl_rd)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      seed_in   = seed_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      pos_in    = pos_ff;
      fixed_in  = fixed_ff;
      fix_in    = fix_ff;
      mod_start = 1'b0;
      rsp_load  = 1'b0;
      tbl_req   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            if (fold_done) begin
               seed_in = fold_result;
               if (cnt_ff == CNT_W'(KEY_BYTES - 1)) begin
                  // last byte: table is already identity, start shuffle at the top
                  cnt_in   = '0;
                  k_in     = TOP_IDX;
                  state_in = S_XS;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_XS: begin
            seed_in   = xs_next;
            mod_start = 1'b1;
            state_in  = S_MOD;
         end
         S_MOD: begin
            if (mod_done) begin
               j_in     = mod_rem;
               state_in = S_RD;
            end
         end
         S_RD: begin
            tbl_req.rd_en     = 1'b1;
            tbl_req.rd_a_addr = k_ff;
            tbl_req.rd_b_addr = j_ff;
            state_in          = S_WK;
         end
         S_WK: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = k_ff;
            tbl_req.wr_data = tbl_rd.b;
            state_in        = S_WJ;
         end
         S_WJ: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = j_ff;
            tbl_req.wr_data = tbl_rd.a;
            if (fix_ff) begin
               pos_in   = '0;
               state_in = S_ERD;
            end else if (k_ff == IDX_W'(1)) begin
               pos_in   = '0;
               fixed_in = '0;
               state_in = S_CRD;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_XS;
            end
         end
         S_CRD: begin
            tbl_req.rd_en     = 1'b1;
            tbl_req.rd_a_addr = pos_ff;
            tbl_req.rd_b_addr = pos_ff;
            state_in          = S_CCHK;
         end
         S_CCHK: begin
            fixed_in = fixed_ff + DIV_W'(tbl_rd.a == pos_ff);
            if (pos_ff == TOP_IDX) begin
               state_in = S_FIX;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         S_FIX: begin
            // nearly the identity: swap entries 0 and 1
            if (({1'b0, fixed_ff} + 1'b1) >= (DIV_W + 1)'(REG_COUNT)) begin
               k_in     = IDX_W'(1);
               j_in     = '0;
               fix_in   = 1'b1;
               state_in = S_RD;
            end else begin
               pos_in   = '0;
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            tbl_req.rd_en     = 1'b1;
            tbl_req.rd_a_addr = pos_ff;
            tbl_req.rd_b_addr = pos_ff;
            state_in          = S_ELD;
         end
         S_ELD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               if (pos_ff == TOP_IDX) begin
                  // run complete: back to the reset state
                  tbl_req.clear = 1'b1;
                  seed_in       = '0;
                  fix_in        = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seed_ff  <= '0;
         cnt_ff   <= '0;
         fix_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         cnt_ff   <= cnt_in;
         fix_ff   <= fix_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      j_ff     <= j_in;
      pos_ff   <= pos_in;
      fixed_ff <= fixed_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_slot_ff   <= pos_ff;
         rsp_target_ff <= tbl_rd.a;
         rsp_last_ff   <= (pos_ff == TOP_IDX);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_target_ff, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   // the last entry leaves the block in its reset state
   a_end_of_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && pos_ff == TOP_IDX) |=> (state_ff == S_IDLE && seed_ff == '0))
      else $error("block not back at reset state after last entry");

   // swap partner never above the index being placed
   a_partner_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (j_ff <= k_ff))
      else $error("swap partner above current index");

   // the fold result only arrives while the sequencer waits for it
   a_fold_timing : assert property (@(posedge clock) disable iff (reset)
      fold_done |-> (state_ff == S_FOLD))
      else $error("fold result outside fold wait");

endmodule

`default_nettype wire

[test/seeded_register_permutation_test.sv]
// self-checking testbench for seeded_register_permutation: key bytes in, shuffled table out
// holds its own seed fold and table shuffle in a scoreboard class; needs srp_pkg and the block
`timescale 1ns / 100ps

module seeded_register_permutation_test;

   localparam int REG_COUNT = 31;
   localparam int KEY_BYTES = 32;
   localparam int RANDOM_RUNS = 14;         // 14 runs of 32 bytes plus one directed run
   localparam int QUIET_RUNS = 3;           // final runs with no idling on either side
   localparam int HOLD_RUN = 3;             // run during which the receiver holds off
   localparam int HOLD_CYCLES = 4000;       // longer than a whole shuffle
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 400000;

   // one table entry as it leaves the block
   typedef struct {
      bit [4:0] slot;
      bit [4:0] target;
      bit       last_entry;
   } table_entry_type;

   // folds key bytes into a seed and, on the last byte, shuffles the table
   // and queues every entry that the block has to stream out
   class perm_scoreboard;
      localparam bit [63:0] SEED_MUL = 64'd1315423911;
      localparam bit [63:0] SEED_ADD = 64'h9E37_79B9_7F4A_7C15;

      bit [63:0]       seed_acc;
      int              bytes_seen;
      int              errors;
      table_entry_type expected_entries[$];

      function new();
         seed_acc = '0;
         bytes_seen = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_entries.size();
      endfunction

      function void shuffle_table();
         bit [4:0]        tbl[REG_COUNT];
         bit [4:0]        swap_tmp;
         bit [63:0]       x;
         int              j;
         int              fixed_count;
         table_entry_type entry;
         for (int k = 0; k < REG_COUNT; k++) tbl[k] = k[4:0];
         // fisher-yates from the top index down, partner from xorshift64
         for (int k = REG_COUNT - 1; k > 0; k--) begin
            x = seed_acc;
            x ^= x << 13;
            x ^= x >> 7;
            x ^= x << 17;
            seed_acc = x;
            j = int'(x % 64'(k + 1));
            swap_tmp = tbl[k];
            tbl[k] = tbl[j];
            tbl[j] = swap_tmp;
         end
         // nearly untouched table: force entries 0 and 1 apart
         fixed_count = 0;
         for (int k = 0; k < REG_COUNT; k++) if (tbl[k] == k[4:0]) fixed_count++;
         if (fixed_count + 1 >= REG_COUNT) begin
            swap_tmp = tbl[0];
            tbl[0] = tbl[1];
            tbl[1] = swap_tmp;
         end
         for (int k = 0; k < REG_COUNT; k++) begin
            entry.slot = k[4:0];
            entry.target = tbl[k];
            entry.last_entry = (k == REG_COUNT - 1);
            expected_entries.push_back(entry);
         end
      endfunction

      function void note_key_byte(bit [7:0] key_byte);
         seed_acc = seed_acc * SEED_MUL + {56'd0, key_byte} + SEED_ADD;
         bytes_seen++;
         if (bytes_seen == KEY_BYTES) begin
            shuffle_table();
            // the block starts over from a clear seed
            seed_acc = '0;
            bytes_seen = 0;
         end
      endfunction

      function void check_entry(bit [4:0] slot, bit [4:0] target, bit last_entry);
         table_entry_type want;
         if (expected_entries.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat slot=%0d target=%0d last=%0b",
                     $time, slot, target, last_entry);
            return;
         end
         want = expected_entries.pop_front();
         if (slot !== want.slot) begin
            errors++;
            $display("%0t: slot mismatch expected=%0d actual=%0d", $time, want.slot, slot);
         end
         if (target !== want.target) begin
            errors++;
            $display("%0t: target mismatch at slot %0d expected=%0d actual=%0d",
                     $time, want.slot, want.target, target);
         end
         if (last_entry !== want.last_entry) begin
            errors++;
            $display("%0t: last_entry mismatch at slot %0d expected=%0b actual=%0b",
                     $time, want.slot, want.last_entry, last_entry);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [7:0] key_byte
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [15:0] rsp_tdata;            // [4:0] slot, [9:5] target, [15:10] zero
   wire         rsp_tlast;            // last_entry

   perm_scoreboard sb;
   bit idle_on = 1'b1;                // random idle bursts allowed on both sides
   bit hold_req = 1'b0;               // asks the receiver for one long hold-off
   int cycle_count = 0;

   seeded_register_permutation #(
      .REG_COUNT(REG_COUNT),
      .KEY_BYTES(KEY_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // offer one key byte and wait for its beat; the scoreboard sees it on acceptance
   task automatic send_key_byte(input bit [7:0] key_byte);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= key_byte;
      do @(posedge clock); while (!req_tready);
      sb.note_key_byte(key_byte);
   endtask

   // a full subkey: directed run walks the extremes, otherwise random bytes
   task automatic send_subkey(input bit directed);
      bit [7:0] pattern[KEY_BYTES] = '{
         8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
         8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF,
         8'hBF, 8'h7F, 8'h55, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'hFF,
         8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h7E, 8'h81, 8'h00, 8'hFF};
      for (int n = 0; n < KEY_BYTES; n++) begin
         if (directed) send_key_byte(pattern[n]);
         else send_key_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // result side: check each beat, then pick the next ready level
   initial begin : result_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_entry(rsp_tdata[4:0], rsp_tdata[9:5], rsp_tlast);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            // long hold-off so the table and then the input stall
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_subkey(1'b1);
      for (int run = 0; run < RANDOM_RUNS; run++) begin
         if (run == HOLD_RUN) hold_req = 1'b1;
         if (run == RANDOM_RUNS - QUIET_RUNS) idle_on = 1'b0;
         send_subkey(1'b0);
      end
      req_tvalid <= 1'b0;

      // let the last table drain, then a short quiet tail
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
